FILE: hw/rtl/iff_pkg.sv
// Package for the integer field formatter: widths, codes and character constants.
// Used by every module of the formatter.
package iff_pkg;

    localparam int MAX_FIELD_DEF     = 48;
    localparam int MAX_PRECISION_DEF = 40;
    localparam int DIGIT_CELLS       = 20;  // 64-bit decimal has at most 20 digits

    // Conversion kinds.
    localparam logic [2:0] FUNC_SDEC = 3'd0;
    localparam logic [2:0] FUNC_UDEC = 3'd1;
    localparam logic [2:0] FUNC_OCT  = 3'd2;
    localparam logic [2:0] FUNC_HEXL = 3'd3;
    localparam logic [2:0] FUNC_HEXU = 3'd4;

    // Operand sizes.
    localparam logic [1:0] SIZE_32 = 2'd0;
    localparam logic [1:0] SIZE_16 = 2'd1;
    localparam logic [1:0] SIZE_64 = 2'd2;

    // Radix selection for the digit cells.
    localparam logic [1:0] RADIX_DEC = 2'd0;
    localparam logic [1:0] RADIX_OCT = 2'd1;
    localparam logic [1:0] RADIX_HEX = 2'd2;

    // Leading sign character of a signed decimal field.
    localparam logic [1:0] SIGN_NONE  = 2'd0;
    localparam logic [1:0] SIGN_MINUS = 2'd1;
    localparam logic [1:0] SIGN_PLUS  = 2'd2;
    localparam logic [1:0] SIGN_SPACE = 2'd3;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_LOWA  = 8'h57;  // 'a' - 10
    localparam logic [7:0] CH_UPA   = 8'h37;  // 'A' - 10
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } state_t;

    // Control from the sequencer to the digit cells.
    typedef struct packed {
        logic       load;   // clear the chain for a new request
        logic       shift;  // shift in one magnitude bit
        logic [1:0] radix;  // RADIX_DEC, RADIX_OCT or RADIX_HEX
        logic       bit_in; // magnitude bit, most significant first
    } cell_ctl_t;

    // Digit value to ASCII.
    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] base_c;
        begin
            base_c = upper ? CH_UPA : CH_LOWA;
            digit_char = (d < 4'd10) ? (CH_ZERO + {4'd0, d}) : (base_c + {4'd0, d});
        end
    endfunction

endpackage

FILE: hw/rtl/integer_field_formatter.sv
// Integer field formatter top level: sequencer, digit chain and output register.
// Conversion: one magnitude bit per cycle through the digit chain in ST_CONV; the first
// character is registered in ST_EMIT after the whole magnitude is shifted in, then one
// character per cycle while the sink is ready. One request at a time: the next is taken
// once the last character is registered.
// Reset (rst_n, asynchronous, active low) returns to idle with no character pending.
module integer_field_formatter
    import iff_pkg::*;
#(
    parameter int MAX_FIELD     = MAX_FIELD_DEF,
    parameter int MAX_PRECISION = MAX_PRECISION_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [2:0] func, [4:3] size_mode, [68:5] value, [69] left_justify, [70] plus_sign,
    // [71] space_sign, [72] alternate_form, [73] zero_pad, [79:74] width,
    // [80] precision_given, [86:81] precision, [87] unused
    input  logic [87:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] character
    output logic [7:0]  m_tdata,
    output logic        m_tlast
);

    localparam int CW = $clog2(MAX_FIELD + MAX_PRECISION + 32);

    state_t state_reg, state_next;

    logic [63:0] mag_reg, mag_next;
    logic [6:0]  bitcnt_reg, bitcnt_next;
    logic [2:0]  func_reg;
    logic        left_reg, zpad_reg, pgiven_reg, alt_reg;
    logic [1:0]  sign_reg;          // one of the SIGN_* codes
    logic [CW-1:0] w_reg, p_reg;
    logic [CW-1:0] pos_reg, pos_next;
    logic        mv_reg, mv_next;
    logic [7:0]  mch_reg, mch_next;
    logic        ml_reg, ml_next;

    cell_ctl_t   ctl;
    logic [DIGIT_CELLS*4-1:0] digits;

    // Input field decode.
    logic [2:0]  in_func;
    logic [1:0]  in_size;
    logic [63:0] in_val;
    logic [5:0]  in_w, in_p;
    logic [63:0] in_mag;
    logic        in_neg;
    logic [1:0]  in_sign;

    assign in_func = s_tdata[2:0];
    assign in_size = s_tdata[4:3];
    assign in_val  = s_tdata[68:5];
    assign in_w    = s_tdata[79:74];
    assign in_p    = s_tdata[86:81];

    // Magnitude and sign selection.
    always_comb
    begin
        in_neg = 1'b0;
        if (in_func == FUNC_SDEC)
        begin
            case (in_size)
                SIZE_16: in_neg = in_val[15];
                SIZE_64: in_neg = in_val[63];
                default: in_neg = in_val[31];
            endcase
        end
        if (in_func == FUNC_SDEC || in_func == FUNC_UDEC)
        begin
            case (in_size)
                SIZE_16: in_mag = {48'd0, in_val[15:0]};
                SIZE_64: in_mag = in_val;
                default: in_mag = {32'd0, in_val[31:0]};
            endcase
        end
        else
        begin
            in_mag = (in_size == SIZE_16) ? {48'd0, in_val[15:0]} : {32'd0, in_val[31:0]};
        end
        if (in_neg)
        begin
            in_mag = 64'd0 - in_mag;
            if (in_size == SIZE_16) in_mag = {48'd0, in_mag[15:0]};
            else if (in_size != SIZE_64) in_mag = {32'd0, in_mag[31:0]};
        end
        if (in_func != FUNC_SDEC) in_sign = SIGN_NONE;
        else if (in_neg)          in_sign = SIGN_MINUS;
        else if (s_tdata[70])     in_sign = SIGN_PLUS;
        else if (s_tdata[71])     in_sign = SIGN_SPACE;
        else                      in_sign = SIGN_NONE;
    end

    // Digit count: index of the highest nonzero digit plus one, at least one.
    logic [4:0] ndig;
    always_comb
    begin
        ndig = 5'd1;
        for (int i = 1; i < DIGIT_CELLS; i++)
        begin
            if (digits[i*4 +: 4] != 4'd0) ndig = 5'(i + 1);
        end
    end

    // Field layout: [sign][prefix][zeros][digits], padding placed per flags.
    logic [CW-1:0] nsign, npfx, nz, nbody, npad, total;
    logic          oct_nz;
    always_comb
    begin
        oct_nz = (func_reg == FUNC_OCT) && alt_reg && (digits != '0);
        nsign = (sign_reg != SIGN_NONE) ? CW'(1) : CW'(0);
        if (func_reg == FUNC_HEXL || func_reg == FUNC_HEXU) npfx = alt_reg ? CW'(2) : CW'(0);
        else npfx = oct_nz ? CW'(1) : CW'(0);
        nz = (p_reg > CW'(ndig)) ? p_reg - CW'(ndig) : CW'(0);
        nbody = nsign + npfx + nz + CW'(ndig);
        npad = (w_reg > nbody) ? w_reg - nbody : CW'(0);
        total = nbody + npad;
        if (total > CW'(MAX_FIELD)) total = CW'(MAX_FIELD);
    end

    // Character at the current position.
    logic [7:0]    ch;
    logic [CW-1:0] q, dgi;
    logic          zmode;
    logic [7:0]    sign_ch;
    always_comb
    begin
        zmode = !left_reg && zpad_reg && !pgiven_reg;
        case (sign_reg)
            SIGN_MINUS: sign_ch = CH_MINUS;
            SIGN_PLUS:  sign_ch = CH_PLUS;
            default:    sign_ch = CH_SPACE;
        endcase
        ch = CH_SPACE;
        q = '0;
        dgi = '0;
        if (left_reg)
        begin
            q = pos_reg;
        end
        else if (zmode)
        begin
            if (pos_reg < nsign) q = pos_reg;
            else if (pos_reg < nsign + npad) q = '1;
            else q = pos_reg - npad;
        end
        else
        begin
            q = (pos_reg < npad) ? '1 : pos_reg - npad;
        end
        if (q == '1)
        begin
            ch = zmode ? CH_ZERO : CH_SPACE;
        end
        else if (q >= nbody)
        begin
            ch = CH_SPACE;
        end
        else if (q < nsign)
        begin
            ch = sign_ch;
        end
        else if (q < nsign + npfx)
        begin
            ch = (q == nsign) ? CH_ZERO : CH_X;
        end
        else if (q < nsign + npfx + nz)
        begin
            ch = CH_ZERO;
        end
        else
        begin
            dgi = nbody - CW'(1) - q;
            ch = digit_char(digits[dgi[4:0]*4 +: 4], func_reg == FUNC_HEXU);
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        mag_next = mag_reg;
        bitcnt_next = bitcnt_reg;
        pos_next = pos_reg;
        mv_next = mv_reg;
        mch_next = mch_reg;
        ml_next = ml_reg;
        ctl.load = 1'b0;
        ctl.shift = 1'b0;
        ctl.bit_in = mag_reg[63];
        case (func_reg)
            FUNC_OCT:  ctl.radix = RADIX_OCT;
            FUNC_HEXL,
            FUNC_HEXU: ctl.radix = RADIX_HEX;
            default:   ctl.radix = RADIX_DEC;
        endcase
        if (mv_reg && m_tready) mv_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && in_func <= FUNC_HEXU)
                begin
                    ctl.load = 1'b1;
                    mag_next = in_mag;
                    bitcnt_next = 7'd0;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                ctl.shift = 1'b1;
                mag_next = {mag_reg[62:0], 1'b0};
                bitcnt_next = bitcnt_reg + 7'd1;
                if (bitcnt_reg == 7'd63)
                begin
                    pos_next = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!mv_reg || m_tready)
                begin
                    mv_next = 1'b1;
                    mch_next = ch;
                    ml_next = (pos_reg + CW'(1) == total);
                    pos_next = pos_reg + CW'(1);
                    if (pos_reg + CW'(1) == total) state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mv_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mv_reg <= mv_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        bitcnt_reg <= bitcnt_next;
        pos_reg <= pos_next;
        mch_reg <= mch_next;
        ml_reg <= ml_next;
        if (s_tready && s_tvalid)
        begin
            func_reg <= in_func;
            left_reg <= s_tdata[69];
            alt_reg <= s_tdata[72];
            zpad_reg <= s_tdata[73];
            pgiven_reg <= s_tdata[80];
            sign_reg <= in_sign;
            w_reg <= (CW'(in_w) > CW'(MAX_FIELD)) ? CW'(MAX_FIELD) : CW'(in_w);
            if (!s_tdata[80]) p_reg <= CW'(1);
            else p_reg <= (CW'(in_p) > CW'(MAX_PRECISION)) ? CW'(MAX_PRECISION) : CW'(in_p);
        end
    end

    iff_digit_chain u_chain (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .digits (digits)
    );

    assign m_tvalid = mv_reg;
    assign m_tdata  = mch_reg;
    assign m_tlast  = ml_reg;

endmodule

FILE: hw/rtl/iff_digit_cell.sv
// One digit cell of the conversion chain: a shift-and-adjust digit register.
// Depends on iff_pkg.
module iff_digit_cell
    import iff_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_ctl_t ctl,
    input  logic      carry_in,   // bit from the lower neighbor
    output logic      carry_out,  // bit handed to the upper neighbor
    output logic [3:0] digit
);

    logic [3:0] d_reg;
    logic [3:0] d_next;
    logic [3:0] adj;

    // Decimal digits get add-3 before the shift; octal and hex shift plainly.
    always_comb
    begin
        adj = d_reg;
        if (ctl.radix == RADIX_DEC && d_reg >= 4'd5)
        begin
            adj = d_reg + 4'd3;
        end
        d_next = d_reg;
        carry_out = 1'b0;
        case (ctl.radix)
            RADIX_DEC:
            begin
                carry_out = adj[3];
                d_next = {adj[2:0], carry_in};
            end
            RADIX_OCT:
            begin
                carry_out = d_reg[2];
                d_next = {1'b0, d_reg[1:0], carry_in};
            end
            default:
            begin
                carry_out = d_reg[3];
                d_next = {d_reg[2:0], carry_in};
            end
        endcase
        if (ctl.load)
        begin
            d_next = 4'd0;
        end
        else if (!ctl.shift)
        begin
            d_next = d_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_reg <= 4'd0;
        end
        else
        begin
            d_reg <= d_next;
        end
    end

    assign digit = d_reg;

endmodule

FILE: hw/rtl/iff_digit_chain.sv
// Row of digit cells that turns a binary magnitude into decimal, octal or hex digits.
// Depends on iff_pkg and iff_digit_cell.
module iff_digit_chain
    import iff_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_ctl_t ctl,
    output logic [DIGIT_CELLS*4-1:0] digits
);

    logic [DIGIT_CELLS:0] carry;

    assign carry[0] = ctl.bit_in;

    for (genvar g = 0; g < DIGIT_CELLS; g++)
    begin : g_cell
        iff_digit_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .carry_in  (carry[g]),
            .carry_out (carry[g+1]),
            .digit     (digits[g*4 +: 4])
        );
    end

endmodule
